FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the serial buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define URB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define URB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/uart_rb_pkg.sv
// Shared types and event codes for the serial buffer engine.
`default_nettype none

package uart_rb_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 2;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_RX_BYTE    = 2'd0;
    localparam kind_t KIND_TX_READY   = 2'd1;
    localparam kind_t KIND_HOST_READ  = 2'd2;
    localparam kind_t KIND_HOST_WRITE = 2'd3;

    // Per-cycle control of one ring.
    typedef struct packed {
        logic              push;       // write at head and advance
        logic              overwrite;  // write at head, pointers stay
        logic              pop;        // advance tail
        logic [BYTE_W-1:0] data;
    } ring_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/uart_rb_ring.sv
// Byte ring with head/tail pointers, a level count and a registered front byte.
`default_nettype none

`include "assert_macros.svh"

module uart_rb_ring #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire uart_rb_pkg::ring_ctrl_t       ctrl,
    output logic [$clog2(DEPTH+1)-1:0]         count,
    output logic [uart_rb_pkg::BYTE_W-1:0]     front
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [uart_rb_pkg::BYTE_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [uart_rb_pkg::BYTE_W-1:0] front_reg;
    logic wr_en;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_en      = ctrl.push | ctrl.overwrite;
        head_next  = ctrl.push ? ptr_inc(head_reg) : head_reg;
        tail_next  = ctrl.pop ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[head_reg] <= ctrl.data;
        end
    end

    // The front byte is registered from the slot at the next tail; a write to that
    // same slot in this cycle is forwarded so the front never goes stale.
    always_ff @(posedge aclk) begin
        if (wr_en && (head_reg == tail_next)) begin
            front_reg <= ctrl.data;
        end else begin
            front_reg <= mem[tail_next];
        end
    end

    assign count = count_reg;
    assign front = front_reg;

    `URB_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH),
        "ring level above depth")
    `URB_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, ctrl.pop, count_reg != '0,
        "pop from empty ring")
    `URB_ASSERT_NOW(a_push_room, aclk, aresetn, ctrl.push,
        (count_reg != CNT_W'(DEPTH)) && !ctrl.overwrite, "push into full ring")

endmodule

`default_nettype wire

FILE: rtl/core/uart_rx_tx_ring_buffers_top.sv
// Top level of the serial buffer engine: event register, ring control, result register.
//
//  Channel  | Direction | Ports                          | Contents
//  ---------+-----------+--------------------------------+------------------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tuser | one event per item
//  m_       | out       | m_tvalid m_tready m_tdata      | one result per event
//  cfg_     | in        | cfg_wr_en cfg_wr_data          | echo enable register
//
// One item per cycle is sustained while the result side does not stall; an event passes the
// input register, then the result register. Each ring update touches one memory slot,
// and the front byte of each ring is held in a register loaded from the next tail slot.
// Reset clears pointers, levels, the interrupt enable and echo; ring contents stay.
// A stalled result blocks further events only once the input register is also full.
`default_nettype none

`include "assert_macros.svh"

module uart_rx_tx_ring_buffers_top #(
    parameter int unsigned RING_DEPTH = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [1:0] s_tuser,   // [1:0] kind

    output logic m_tvalid,
    input  wire logic m_tready,
    // [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
    // then rx_level, tx_level, tx_irq_enable, rx_overrun, tx_dropped, zero fill
    output logic [((4*uart_rb_pkg::BYTE_W/4*2 + 5 + 2*$clog2(RING_DEPTH+1)) + 7) / 8 * 8 - 1:0]
                 m_tdata,

    input  wire logic cfg_wr_en,
    input  wire logic cfg_wr_data
);

    localparam int unsigned LVL_W = $clog2(RING_DEPTH + 1);
    localparam int unsigned RES_W = 2 * uart_rb_pkg::BYTE_W + 5 + 2 * LVL_W;
    localparam int unsigned OUT_W = (RES_W + 7) / 8 * 8;

    logic                           in_vld_reg, in_vld_next;
    uart_rb_pkg::kind_t             in_kind_reg;
    logic [uart_rb_pkg::BYTE_W-1:0] in_byte_reg;
    logic                           out_vld_reg, out_vld_next;
    logic [RES_W-1:0]               out_data_reg;
    logic                           echo_reg;
    logic                           tie_reg, tie_next;
    logic                           advance;
    logic                           s_accept;

    uart_rb_pkg::ring_ctrl_t        rx_ctrl, tx_ctrl;
    logic [LVL_W-1:0]               rx_count, tx_count;
    logic [uart_rb_pkg::BYTE_W-1:0] rx_front, tx_front;
    logic                           rx_full, tx_full;

    logic                           line_valid, read_valid, overrun, dropped;
    logic [uart_rb_pkg::BYTE_W-1:0] line_byte, read_byte;
    logic [LVL_W-1:0]               rx_level, tx_level;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign rx_full = (rx_count == LVL_W'(RING_DEPTH));
    assign tx_full = (tx_count == LVL_W'(RING_DEPTH));

    always_comb begin
        rx_ctrl    = '0;
        tx_ctrl    = '0;
        line_valid = 1'b0;
        line_byte  = '0;
        read_valid = 1'b0;
        read_byte  = '0;
        overrun    = 1'b0;
        dropped    = 1'b0;
        tie_next   = tie_reg;
        if (advance) begin
            unique case (in_kind_reg)
                uart_rb_pkg::KIND_RX_BYTE: begin
                    // A full ring takes the byte in the head slot without moving.
                    rx_ctrl.push      = !rx_full;
                    rx_ctrl.overwrite = rx_full;
                    rx_ctrl.data      = in_byte_reg;
                    overrun           = rx_full;
                    if (tx_count == '0) begin
                        tie_next = 1'b0;
                    end
                end
                uart_rb_pkg::KIND_TX_READY: begin
                    if (tx_count != '0) begin
                        line_valid  = 1'b1;
                        line_byte   = tx_front;
                        tx_ctrl.pop = 1'b1;
                    end
                    if (tx_count <= LVL_W'(1)) begin
                        tie_next = 1'b0;
                    end
                end
                uart_rb_pkg::KIND_HOST_READ: begin
                    if (rx_count != '0) begin
                        read_valid  = 1'b1;
                        read_byte   = rx_front;
                        rx_ctrl.pop = 1'b1;
                        if (echo_reg) begin
                            dropped      = tx_full;
                            tx_ctrl.push = !tx_full;
                            tx_ctrl.data = rx_front;
                            if (tx_count == '0) begin
                                tie_next = 1'b1;
                            end
                        end
                    end
                end
                uart_rb_pkg::KIND_HOST_WRITE: begin
                    dropped      = tx_full;
                    tx_ctrl.push = !tx_full;
                    tx_ctrl.data = in_byte_reg;
                    if (tx_count == '0) begin
                        tie_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        rx_level = rx_count + LVL_W'(rx_ctrl.push) - LVL_W'(rx_ctrl.pop);
        tx_level = tx_count + LVL_W'(tx_ctrl.push) - LVL_W'(tx_ctrl.pop);
    end

    always_comb begin
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            echo_reg    <= 1'b0;
            tie_reg     <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            tie_reg     <= tie_next;
            if (cfg_wr_en) begin
                echo_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= {dropped, overrun, tie_next, tx_level, rx_level,
                             read_byte, read_valid, line_byte, line_valid};
        end
    end

    uart_rb_ring #(
        .DEPTH (RING_DEPTH)
    ) u_rx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rx_ctrl),
        .count   (rx_count),
        .front   (rx_front)
    );

    uart_rb_ring #(
        .DEPTH (RING_DEPTH)
    ) u_tx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tx_ctrl),
        .count   (tx_count),
        .front   (tx_front)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    `URB_ASSERT_NEXT(a_advance_result, aclk, aresetn, advance, out_vld_reg,
        "processed event left no result")
    `URB_ASSERT_NOW(a_tie_empty, aclk, aresetn, tie_reg, tx_count != '0,
        "transmit interrupt enabled with empty transmit ring")

endmodule

`default_nettype wire

FILE: tb/uart_rx_tx_ring_buffers_top_tb.sv
// Self-checking testbench for the serial buffer engine with its receive and transmit rings.
module uart_rx_tx_ring_buffers_top_tb;

    localparam int unsigned RING_DEPTH = 64;
    localparam int unsigned HOLD_CYCLES = 300;

    // Result word as packed on m_tdata, top bits first.
    typedef struct packed {
        logic [4:0] fill;
        logic       tx_dropped;
        logic       rx_overrun;
        logic       tx_irq_enable;
        logic [6:0] tx_level;
        logic [6:0] rx_level;
        logic [7:0] read_byte;
        logic       read_valid;
        logic [7:0] line_byte;
        logic       line_valid;
    } uart_result_t;

    class uart_ring_scoreboard;
        localparam int unsigned DEPTH = 64;
        logic [7:0] rx_ring [DEPTH];
        logic [7:0] tx_ring [DEPTH];
        int unsigned rx_wr, rx_rd, rx_cnt;
        int unsigned tx_wr, tx_rd, tx_cnt;
        bit irq_en;
        bit echo_on;
        uart_result_t awaited_results [$];
        int unsigned failures;

        function new();
            rx_wr = 0; rx_rd = 0; rx_cnt = 0;
            tx_wr = 0; tx_rd = 0; tx_cnt = 0;
            irq_en = 1'b0;
            echo_on = 1'b0;
            failures = 0;
        endfunction

        function void set_echo(bit on);
            echo_on = on;
        endfunction

        // Returns 1 when the transmit ring had no room for the byte.
        function bit queue_tx(logic [7:0] b);
            if (tx_cnt >= DEPTH) return 1'b1;
            tx_ring[tx_wr] = b;
            tx_wr = (tx_wr + 1) % DEPTH;
            tx_cnt++;
            if (tx_cnt == 1) irq_en = 1'b1;
            return 1'b0;
        endfunction

        function void note_event(uart_rb_pkg::kind_t kind, logic [7:0] b);
            uart_result_t r;
            r = '0;
            case (kind)
                uart_rb_pkg::KIND_RX_BYTE: begin
                    // A full ring keeps its pointers; the slot at the head is overwritten.
                    rx_ring[rx_wr] = b;
                    if (rx_cnt < DEPTH) begin
                        rx_wr = (rx_wr + 1) % DEPTH;
                        rx_cnt++;
                    end else begin
                        r.rx_overrun = 1'b1;
                    end
                    if (tx_cnt == 0) irq_en = 1'b0;
                end
                uart_rb_pkg::KIND_TX_READY: begin
                    if (tx_cnt > 0) begin
                        r.line_valid = 1'b1;
                        r.line_byte = tx_ring[tx_rd];
                        tx_rd = (tx_rd + 1) % DEPTH;
                        tx_cnt--;
                    end
                    if (tx_cnt == 0) irq_en = 1'b0;
                end
                uart_rb_pkg::KIND_HOST_READ: begin
                    if (rx_cnt > 0) begin
                        r.read_valid = 1'b1;
                        r.read_byte = rx_ring[rx_rd];
                        rx_rd = (rx_rd + 1) % DEPTH;
                        rx_cnt--;
                        if (echo_on) r.tx_dropped = queue_tx(r.read_byte);
                    end
                end
                uart_rb_pkg::KIND_HOST_WRITE: begin
                    r.tx_dropped = queue_tx(b);
                end
            endcase
            r.rx_level = rx_cnt[6:0];
            r.tx_level = tx_cnt[6:0];
            r.tx_irq_enable = irq_en;
            awaited_results.push_back(r);
        endfunction

        function void check_result(uart_result_t got);
            uart_result_t want;
            bit bad;
            if (awaited_results.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected result %h", got);
                return;
            end
            want = awaited_results.pop_front();
            bad = (got.line_valid !== want.line_valid) || (got.line_byte !== want.line_byte)
                || (got.read_valid !== want.read_valid) || (got.read_byte !== want.read_byte)
                || (got.rx_level !== want.rx_level) || (got.tx_level !== want.tx_level)
                || (got.tx_irq_enable !== want.tx_irq_enable)
                || (got.rx_overrun !== want.rx_overrun) || (got.tx_dropped !== want.tx_dropped)
                || (got.fill !== want.fill);
            if (bad) begin
                failures++;
                if (failures <= 10) begin
                    $write("mismatch expected: lv=%0d lb=%h rv=%0d rb=%h rx=%0d",
                           want.line_valid, want.line_byte, want.read_valid, want.read_byte,
                           want.rx_level);
                    $display(" tx=%0d ie=%0d ov=%0d dr=%0d fill=%h",
                             want.tx_level, want.tx_irq_enable, want.rx_overrun,
                             want.tx_dropped, want.fill);
                    $write("         actual:   lv=%0d lb=%h rv=%0d rb=%h rx=%0d",
                           got.line_valid, got.line_byte, got.read_valid, got.read_byte,
                           got.rx_level);
                    $display(" tx=%0d ie=%0d ov=%0d dr=%0d fill=%h",
                             got.tx_level, got.tx_irq_enable, got.rx_overrun,
                             got.tx_dropped, got.fill);
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_wr_data;

    uart_ring_scoreboard ring_model = new();

    int unsigned hold_asked = 0;
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned ready_cycle;
    int unsigned stall_mode;

    uart_rx_tx_ring_buffers_top #(
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) ring_model.note_event(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) ring_model.check_result(m_tdata);
    end

    // The result side periodically picks a stall pattern at random and can be asked
    // for one long hold-off so that the engine backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_cycle <= 0;
            stall_mode <= 0;
            hold_left <= 0;
            hold_served <= 0;
        end else begin
            ready_cycle <= ready_cycle + 1;
            if (ready_cycle % 64 == 0) stall_mode <= $urandom_range(0, 2);
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_asked != hold_served) begin
                m_tready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_served <= hold_served + 1;
            end else begin
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    task automatic send_event(uart_rb_pkg::kind_t kind, logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_echo(bit on);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= on;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ring_model.set_echo(on);
    endtask

    task automatic wait_drained();
        while (ring_model.awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic uart_rb_pkg::kind_t pick_kind(int unsigned w_rx, int unsigned w_ready,
                                                     int unsigned w_read, int unsigned w_write);
        int unsigned r;
        r = $urandom_range(0, w_rx + w_ready + w_read + w_write - 1);
        if (r < w_rx) return uart_rb_pkg::KIND_RX_BYTE;
        if (r < w_rx + w_ready) return uart_rb_pkg::KIND_TX_READY;
        if (r < w_rx + w_ready + w_read) return uart_rb_pkg::KIND_HOST_READ;
        return uart_rb_pkg::KIND_HOST_WRITE;
    endfunction

    task automatic run_phase(int unsigned count, int unsigned w_rx, int unsigned w_ready,
                             int unsigned w_read, int unsigned w_write);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_event(pick_kind(w_rx, w_ready, w_read, w_write), $urandom_range(0, 255));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 || sent >= count) s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = uart_rb_pkg::KIND_RX_BYTE;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_echo(1'b0);

        // Empty rings first, then byte extremes through both rings.
        send_event(uart_rb_pkg::KIND_HOST_READ, 8'h3c);
        send_event(uart_rb_pkg::KIND_TX_READY, 8'hc3);
        send_event(uart_rb_pkg::KIND_RX_BYTE, 8'h00);
        send_event(uart_rb_pkg::KIND_RX_BYTE, 8'hff);
        send_event(uart_rb_pkg::KIND_RX_BYTE, 8'h5a);
        send_event(uart_rb_pkg::KIND_HOST_WRITE, 8'hff);
        send_event(uart_rb_pkg::KIND_HOST_WRITE, 8'h00);
        send_event(uart_rb_pkg::KIND_RX_BYTE, 8'ha5);
        send_event(uart_rb_pkg::KIND_TX_READY, 8'h11);
        send_event(uart_rb_pkg::KIND_TX_READY, 8'h22);
        send_event(uart_rb_pkg::KIND_TX_READY, 8'h33);
        send_event(uart_rb_pkg::KIND_HOST_READ, 8'h44);
        send_event(uart_rb_pkg::KIND_HOST_READ, 8'h55);
        send_event(uart_rb_pkg::KIND_HOST_WRITE, 8'h81);
        s_tvalid <= 1'b0;
        wait_drained();

        // Reads now echo into the transmit ring.
        write_echo(1'b1);
        send_event(uart_rb_pkg::KIND_HOST_READ, 8'hee);
        send_event(uart_rb_pkg::KIND_HOST_READ, 8'h77);
        send_event(uart_rb_pkg::KIND_HOST_READ, 8'h99);
        send_event(uart_rb_pkg::KIND_TX_READY, 8'h66);
        send_event(uart_rb_pkg::KIND_TX_READY, 8'h01);
        send_event(uart_rb_pkg::KIND_TX_READY, 8'h80);
        s_tvalid <= 1'b0;
        wait_drained();

        write_echo(1'b0);
        run_phase(150, 1, 1, 1, 1);
        wait_drained();

        // Fill both rings while the result side is held off.
        hold_asked = hold_asked + 1;
        run_phase(220, 9, 1, 1, 9);
        wait_drained();

        // Echo into a full transmit ring, then drain with echo still on.
        write_echo(1'b1);
        run_phase(150, 1, 1, 6, 2);
        wait_drained();
        run_phase(200, 2, 5, 3, 1);
        wait_drained();

        write_echo(1'b0);
        run_phase(230, 3, 3, 3, 3);
        wait_drained();
        repeat (10) @(posedge aclk);

        if (ring_model.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
